>>> rtl/biou_pkg.sv
package biou_pkg;

	localparam int COORD_W = 16;
	localparam int DIM_W   = COORD_W + 2;
	localparam int PROD_W  = 2 * DIM_W;
	localparam int AREA_W  = 34;
	localparam int UNI_W   = AREA_W + 2;
	localparam int NUM_W   = AREA_W - 1;
	localparam int REM_W   = AREA_W + 1;
	localparam int OVL_W   = 17;
	localparam int STEP_W  = $clog2(OVL_W + 1);
	localparam int IDX_W   = 6;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_MEASURE = 2'd2
	} op_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] y2;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] x1;
	} box_t;

	typedef struct packed {
		logic signed [AREA_W-1:0] area;
		box_t                     box;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  numer;
		logic [AREA_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [OVL_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> rtl/biou_table.sv
module biou_table import biou_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

>>> rtl/biou_div.sv
module biou_div import biou_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [REM_W-1:0]  rem_q;
	logic [AREA_W-1:0] denom_q;
	logic [OVL_W-1:0]  quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic              ge;
	logic [REM_W-1:0]  diff;
	logic [REM_W-1:0]  nrem;

	// restoring division, one quotient bit per cycle, MSB first
	assign ge   = rem_q >= REM_W'(denom_q);
	assign diff = rem_q - REM_W'(denom_q);
	assign nrem = ge ? diff : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(OVL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= REM_W'(req.numer);
			denom_q <= req.denom;
			quot_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[OVL_W-2:0], ge};
			rem_q  <= {nrem[REM_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

>>> rtl/box_iou_table.sv
// Box overlap table.
// The cmd channel carries op and one box (x1, y1, x2, y2, inclusive pixels).
// A clear transaction empties the table, an append stores one reference box
// (dropped when the table already holds MAX_QUERY boxes), and a measure
// returns on the res channel one overlap per stored box, in storage order,
// with ref_index naming each box and last marking the final one. Overlap is
// IoU in unsigned Q1.16, floor rounded. A measure against an empty table and
// op code three return nothing.
// cmd_stall is high while a transaction is in work; a clear leaves it low. An
// append passes through ST_APPEND. A measure finds the query area, then for
// each stored box steps through the table read, the overlap edges, one pass
// through the shared 18x18 multiplier and the union, and for a box that
// overlaps the query box also through the restoring divider (17 one-bit
// steps). The block works on one transaction at a time.
// While res_stall is high the current result is held and the sequencer waits.
// Reset empties the table and drops any result in flight; table contents
// are not cleared.
module box_iou_table import biou_pkg::*; #(
	parameter int MAX_QUERY = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  logic [1:0]                op,
	input  logic signed [COORD_W-1:0] x1,
	input  logic signed [COORD_W-1:0] y1,
	input  logic signed [COORD_W-1:0] x2,
	input  logic signed [COORD_W-1:0] y2,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [OVL_W-1:0]          overlap,
	output logic [IDX_W-1:0]          ref_index,
	output logic                      last
);

	localparam int IW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
	localparam int CW = $clog2(MAX_QUERY + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_QUERY);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPEND,
		ST_QAREA,
		ST_READ,
		ST_EDGE,
		ST_MUL,
		ST_UNION,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [IW-1:0]            k_q;
	box_t                     qbox_q;
	logic signed [AREA_W-1:0] qarea_q;
	logic signed [AREA_W-1:0] rarea_q;
	logic signed [DIM_W-1:0]  iw_q;
	logic signed [DIM_W-1:0]  ih_q;
	logic                     pos_q;
	logic signed [AREA_W-1:0] inter_q;
	logic                     res_valid_q;
	logic [OVL_W-1:0]         overlap_q;
	logic [IDX_W-1:0]         ref_index_q;
	logic                     last_q;

	entry_t                   wr_data;
	entry_t                   rd_data;
	logic                     wr_en;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	logic signed [DIM_W-1:0]  qw;
	logic signed [DIM_W-1:0]  qh;
	logic signed [COORD_W-1:0] min_x2, max_x1, min_y2, max_y1;
	logic signed [DIM_W-1:0]  iw;
	logic signed [DIM_W-1:0]  ih;
	logic signed [DIM_W-1:0]  mul_a;
	logic signed [DIM_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [UNI_W-1:0]  uni;
	logic                     uni_ok;
	logic                     is_last;

	assign qw = DIM_W'(qbox_q.x2) - DIM_W'(qbox_q.x1) + DIM_W'(1);
	assign qh = DIM_W'(qbox_q.y2) - DIM_W'(qbox_q.y1) + DIM_W'(1);

	assign min_x2 = (qbox_q.x2 < rd_data.box.x2) ? qbox_q.x2 : rd_data.box.x2;
	assign max_x1 = (qbox_q.x1 > rd_data.box.x1) ? qbox_q.x1 : rd_data.box.x1;
	assign min_y2 = (qbox_q.y2 < rd_data.box.y2) ? qbox_q.y2 : rd_data.box.y2;
	assign max_y1 = (qbox_q.y1 > rd_data.box.y1) ? qbox_q.y1 : rd_data.box.y1;
	assign iw = DIM_W'(min_x2) - DIM_W'(max_x1) + DIM_W'(1);
	assign ih = DIM_W'(min_y2) - DIM_W'(max_y1) + DIM_W'(1);

	// one multiplier: box areas on append and measure, intersection per entry
	assign mul_a = (state_q == ST_MUL) ? iw_q : qw;
	assign mul_b = (state_q == ST_MUL) ? ih_q : qh;
	assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign uni    = UNI_W'(qarea_q) + UNI_W'(rarea_q) - UNI_W'(inter_q);
	assign uni_ok = !uni[UNI_W-1] && (uni != '0);

	assign is_last = (CW'(k_q) + CW'(1)) == count_q;

	assign wr_en        = (state_q == ST_APPEND);
	assign wr_data.box  = qbox_q;
	assign wr_data.area = prod[AREA_W-1:0];

	assign div_req.start = (state_q == ST_UNION) && pos_q && uni_ok;
	assign div_req.numer = inter_q[NUM_W-1:0];
	assign div_req.denom = uni[AREA_W-1:0];

	biou_table #(
		.DEPTH (MAX_QUERY),
		.AW    (IW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (wr_data),
		.rd_addr (k_q),
		.rd_data (rd_data)
	);

	biou_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			qbox_q      <= '0;
			qarea_q     <= '0;
			rarea_q     <= '0;
			iw_q        <= '0;
			ih_q        <= '0;
			pos_q       <= 1'b0;
			inter_q     <= '0;
			res_valid_q <= 1'b0;
			overlap_q   <= '0;
			ref_index_q <= '0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						qbox_q.x1 <= x1;
						qbox_q.y1 <= y1;
						qbox_q.x2 <= x2;
						qbox_q.y2 <= y2;
						k_q       <= '0;
						case (op_t'(op))
							OP_CLEAR: begin
								count_q <= '0;
							end
							OP_APPEND: begin
								if (count_q < FULL) begin
									state_q <= ST_APPEND;
								end
							end
							OP_MEASURE: begin
								if (count_q != '0) begin
									state_q <= ST_QAREA;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_APPEND: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_IDLE;
				end
				ST_QAREA: begin
					qarea_q <= prod[AREA_W-1:0];
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					iw_q    <= iw;
					ih_q    <= ih;
					pos_q   <= !iw[DIM_W-1] && (iw != '0) && !ih[DIM_W-1] && (ih != '0);
					rarea_q <= rd_data.area;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					inter_q <= prod[AREA_W-1:0];
					state_q <= ST_UNION;
				end
				ST_UNION: begin
					if (pos_q && uni_ok) begin
						state_q <= ST_DIV;
					end else begin
						res_valid_q <= 1'b1;
						overlap_q   <= '0;
						ref_index_q <= IDX_W'(k_q);
						last_q      <= is_last;
						state_q     <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						res_valid_q <= 1'b1;
						overlap_q   <= div_rsp.quot;
						ref_index_q <= IDX_W'(k_q);
						last_q      <= is_last;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the transaction is taken, then advance
					if (!res_stall) begin
						res_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + IW'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign overlap   = overlap_q;
	assign ref_index = ref_index_q;
	assign last      = last_q;

endmodule
